FILE: rtl/ifsc_pkg.sv
// Shared types and constants for the IP flow steering classifier.
package ifsc_pkg;

  localparam int MAX_QUEUES_DEF = 256;

  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_TCP     = 2'd1;
  localparam logic [1:0] ACT_UDP     = 2'd2;
  localparam logic [1:0] ACT_GENERIC = 2'd3;

  localparam logic [2:0] WHY_NONE       = 3'd0;
  localparam logic [2:0] WHY_SHORT      = 3'd1;
  localparam logic [2:0] WHY_BAD_HLEN   = 3'd2;
  localparam logic [2:0] WHY_TCP_SHORT  = 3'd3;
  localparam logic [2:0] WHY_TCP_OFFSET = 3'd4;
  localparam logic [2:0] WHY_UDP_SHORT  = 3'd5;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] MIN_FRAME  = 16'd20;
  localparam logic [15:0] FRAG_MASK  = 16'h3FFF;
  localparam logic [3:0]  MIN_IHL_W  = 4'd5;
  localparam logic [6:0]  TCP_HDR    = 7'd20;
  localparam logic [6:0]  UDP_HDR    = 7'd8;
  localparam logic [3:0]  MCAST_TOP  = 4'hE;

  // First stage: header decoded into flags, length sums and the hash byte.
  typedef struct packed {
    logic        short_frame;
    logic        fragment;
    logic        bad_ihl;
    logic        is_tcp;
    logic        is_udp;
    logic        thoff_bad;
    logic        group;
    logic [15:0] flen;
    logic [6:0]  ihl;
    logic [6:0]  tcp_min;
    logic [6:0]  tcp_full;
    logic [6:0]  udp_min;
    logic [7:0]  hash;
  } dec_t;

  // Second stage: length compares resolved, hash masked.
  typedef struct packed {
    logic       short_frame;
    logic       fragment;
    logic       bad_ihl;
    logic       is_tcp;
    logic       is_udp;
    logic       thoff_bad;
    logic       group;
    logic       tcp_min_short;
    logic       tcp_full_short;
    logic       udp_short;
    logic       ihl_short;
    logic [7:0] qidx;
  } chk_t;

endpackage

FILE: rtl/ifsc_decode.sv
// Stage one: decode header fields into flags, length sums and the hash byte.
module ifsc_decode import ifsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [15:0] frame_length,
  input  logic [15:0] frag_field,
  input  logic [3:0]  header_words,
  input  logic [7:0]  protocol,
  input  logic [15:0] total_length,
  input  logic [3:0]  tcp_offset_words,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic        dest_is_broadcast,
  output logic        dn_valid,
  input  logic        dn_ready,
  output dec_t        dn_data
);

  logic [6:0] ihl;
  logic [6:0] thoff;
  dec_t       dec;

  assign ihl   = {1'b0, header_words, 2'b00};
  assign thoff = {1'b0, tcp_offset_words, 2'b00};

  always_comb begin
    dec.short_frame = frame_length < MIN_FRAME;
    dec.fragment    = (frag_field & FRAG_MASK) != 16'd0;
    dec.bad_ihl     = header_words < MIN_IHL_W;
    dec.is_tcp      = protocol == PROTO_TCP;
    dec.is_udp      = protocol == PROTO_UDP;
    dec.thoff_bad   = (thoff < TCP_HDR) || ({9'd0, thoff} > total_length);
    dec.group       = (destination_address[31:28] == MCAST_TOP) || dest_is_broadcast;
    dec.flen        = frame_length;
    dec.ihl         = ihl;
    dec.tcp_min     = ihl + TCP_HDR;
    dec.tcp_full    = ihl + thoff;
    dec.udp_min     = ihl + UDP_HDR;
    dec.hash        = source_address[7:0] ^ destination_address[7:0]
                    ^ source_port[7:0] ^ destination_port[7:0];
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dec;
    end
  end

endmodule

FILE: rtl/ifsc_check.sv
// Stage two: compare frame length against header sums and mask the hash.
module ifsc_check import ifsc_pkg::*; #(
  parameter int MAX_QUEUES = MAX_QUEUES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] queue_mask,
  input  logic       up_valid,
  output logic       up_ready,
  input  dec_t       up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output chk_t       dn_data
);

  localparam logic [7:0] QLIMIT = 8'(MAX_QUEUES - 1);

  chk_t chk;

  always_comb begin
    chk.short_frame    = up_data.short_frame;
    chk.fragment       = up_data.fragment;
    chk.bad_ihl        = up_data.bad_ihl;
    chk.is_tcp         = up_data.is_tcp;
    chk.is_udp         = up_data.is_udp;
    chk.thoff_bad      = up_data.thoff_bad;
    chk.group          = up_data.group;
    chk.tcp_min_short  = up_data.flen < {9'd0, up_data.tcp_min};
    chk.tcp_full_short = up_data.flen < {9'd0, up_data.tcp_full};
    chk.udp_short      = up_data.flen < {9'd0, up_data.udp_min};
    chk.ihl_short      = up_data.flen < {9'd0, up_data.ihl};
    chk.qidx           = up_data.hash & queue_mask & QLIMIT;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= chk;
    end
  end

endmodule

FILE: rtl/ifsc_decide.sv
// Stage three: resolve check priority into the steering decision.
module ifsc_decide import ifsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  chk_t       up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output logic [1:0] action,
  output logic [7:0] queue_index,
  output logic [2:0] drop_reason
);

  logic [1:0] act_next;
  logic [7:0] qidx_next;
  logic [2:0] why_next;

  always_comb begin
    act_next  = ACT_GENERIC;
    qidx_next = 8'd0;
    why_next  = WHY_NONE;
    if (up_data.short_frame) begin
      act_next = ACT_DROP;
      why_next = WHY_SHORT;
    end else if (up_data.fragment) begin
      act_next = ACT_GENERIC;
    end else if (up_data.bad_ihl) begin
      act_next = ACT_DROP;
      why_next = WHY_BAD_HLEN;
    end else if (up_data.is_tcp) begin
      if (up_data.tcp_min_short) begin
        act_next = ACT_DROP;
        why_next = WHY_TCP_SHORT;
      end else if (up_data.thoff_bad) begin
        act_next = ACT_DROP;
        why_next = WHY_TCP_OFFSET;
      end else if (up_data.tcp_full_short) begin
        act_next = ACT_DROP;
        why_next = WHY_TCP_SHORT;
      end else begin
        act_next  = ACT_TCP;
        qidx_next = up_data.qidx;
      end
    end else if (up_data.is_udp) begin
      if (up_data.udp_short) begin
        act_next = ACT_DROP;
        why_next = WHY_UDP_SHORT;
      end else begin
        act_next  = ACT_UDP;
        qidx_next = up_data.group ? 8'd0 : up_data.qidx;
      end
    end else if (up_data.ihl_short) begin
      act_next = ACT_DROP;
      why_next = WHY_BAD_HLEN;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      action      <= act_next;
      queue_index <= qidx_next;
      drop_reason <= why_next;
    end
  end

endmodule

FILE: rtl/ip_flow_steering_classifier.sv
// Top level of the IP flow steering classifier.
//
// Steers one received IPv4 header per beat to a drop, the TCP queue, the UDP
// queue or generic queue 0. The input channel (in_valid/in_ready) carries the
// decoded header fields and L4 ports; the output channel (out_valid/out_ready)
// carries action, queue_index and drop_reason. Every input beat yields
// exactly one output beat, in order.
//
// Pipeline: decode -> length check and hash mask -> decision register.
// out_valid rises once a beat has passed through all three registered stages;
// throughput is one beat per cycle while out_ready stays high, as each stage
// takes a beat per cycle when the next has room. Each stage holds
// its own valid bit and advances when the next stage is empty or draining, so
// in_ready stays high while any stage has room.
//
// When out_ready is low, results hold in place and the stages fill up; after
// three held beats in_ready drops until the receiver takes one. Nothing is
// dropped or repeated.
//
// Reset (rst, synchronous) empties all stages and clears queue_mask to 0, so
// every hashed decision lands on queue 0 until queue_mask is written through
// cfg_we/cfg_wdata (write only while the pipeline is empty).
module ip_flow_steering_classifier import ifsc_pkg::*; #(
  parameter int MAX_QUEUES = MAX_QUEUES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frame_length,
  input  logic [15:0] frag_field,
  input  logic [3:0]  header_words,
  input  logic [7:0]  protocol,
  input  logic [15:0] total_length,
  input  logic [3:0]  tcp_offset_words,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic        dest_is_broadcast,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [7:0]  queue_index,
  output logic [2:0]  drop_reason
);

  logic [7:0] queue_mask;
  logic       dec_valid;
  logic       dec_ready;
  dec_t       dec_data;
  logic       chk_valid;
  logic       chk_ready;
  chk_t       chk_data;

  // Queue mask register; the hash is ANDed with it in the check stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mask <= 8'd0;
    end else if (cfg_we) begin
      queue_mask <= cfg_wdata;
    end
  end

  // Decode flags, header length sums and the XOR of the low bytes.
  ifsc_decode u_decode (
    .clk                 (clk),
    .rst                 (rst),
    .up_valid            (in_valid),
    .up_ready            (in_ready),
    .frame_length        (frame_length),
    .frag_field          (frag_field),
    .header_words        (header_words),
    .protocol            (protocol),
    .total_length        (total_length),
    .tcp_offset_words    (tcp_offset_words),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port         (source_port),
    .destination_port    (destination_port),
    .dest_is_broadcast   (dest_is_broadcast),
    .dn_valid            (dec_valid),
    .dn_ready            (dec_ready),
    .dn_data             (dec_data)
  );

  // Compare frame length against the sums and mask the hash.
  ifsc_check #(
    .MAX_QUEUES (MAX_QUEUES)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .queue_mask (queue_mask),
    .up_valid   (dec_valid),
    .up_ready   (dec_ready),
    .up_data    (dec_data),
    .dn_valid   (chk_valid),
    .dn_ready   (chk_ready),
    .dn_data    (chk_data)
  );

  // Pick the first failing check in order and register the result.
  ifsc_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (chk_valid),
    .up_ready    (chk_ready),
    .up_data     (chk_data),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .action      (action),
    .queue_index (queue_index),
    .drop_reason (drop_reason)
  );

endmodule
